// ----- hdl/pidis_pkg.sv -----
// Package for the PID controller with integral separation.
// Types, register indexes, fixed-point constants and rounding helpers.
// No dependencies.
`default_nettype none
package pidis_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_P, S_N, S_B, S_FA, S_FB, S_DM, S_DD,
    S_IM, S_ID, S_TP, S_TI, S_TD, S_OUT
  } state_e;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_req_t;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_STEP_MS   = 3'd3,
    REG_ERR_LIM   = 3'd4,
    REG_INT_LIM   = 3'd5,
    REG_CUTOFF    = 3'd6,
    REG_NONE      = 3'd7
  } reg_idx_e;

  localparam int unsigned WordW   = 64;
  localparam int unsigned MulBits = 32;
  localparam int unsigned DivBits = 64;

  localparam logic [15:0]      TwoPiQ13   = 16'd51472;
  localparam logic [WordW-1:0] FiltDen    = 64'd1000 << 29;
  localparam logic [WordW-1:0] FiltNum    = 64'd1000 << 53;
  localparam logic [24:0]      CoefOne    = 25'd1 << 24;
  localparam logic [31:0]      DerivScale = 32'd1000;
  localparam logic [WordW-1:0] IntDiv     = 64'd2000 << 16;
  localparam logic [30:0]      StepReset  = 31'd65536;

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    abs64 = x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    abs32 = x[31] ? 32'(-x) : 32'(x);
  endfunction

  // round to nearest, halves away from zero, then divide by 2^sh
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                   input int sh);
    logic [63:0] mag;
    logic [63:0] q;
    mag = abs64(x);
    q = (mag + (64'd1 << (sh - 1))) >> sh;
    rnd_shift = x[63] ? $signed(-q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/pidis_muldiv.sv -----
// Shared radix-2 multiply / restoring divide unit, unsigned, one bit per cycle.
// Multiply: 64 x 32 bits. Divide: 64 / 64 bits.
// Depends on pidis_pkg.
`default_nettype none
module pidis_muldiv (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  pidis_pkg::md_req_t   req_i,
  input  wire  [63:0]          a_i,
  input  wire  [63:0]          b_i,
  output logic [63:0]          res_o,
  output logic                 busy_o,
  output logic                 done_o
);

  logic [63:0]       a_q, b_q, r_q;
  logic [6:0]        cnt_q;
  logic              done_q;
  pidis_pkg::md_op_e op_q;

  logic [64:0] rem_sh;
  logic [65:0] rem_diff;

  assign rem_sh   = {r_q, a_q[63]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      op_q   <= pidis_pkg::MD_MUL;
    end else begin
      done_q <= (cnt_q == 7'd1);
      if (req_i.start) begin
        op_q  <= req_i.op;
        cnt_q <= (req_i.op == pidis_pkg::MD_MUL) ? 7'(pidis_pkg::MulBits)
                                                  : 7'(pidis_pkg::DivBits);
      end else if (cnt_q != 7'd0) begin
        cnt_q <= cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= a_i;
      b_q <= (req_i.op == pidis_pkg::MD_MUL) ? {32'd0, b_i[31:0]} : b_i;
      r_q <= '0;
    end else if (cnt_q != 7'd0) begin
      if (op_q == pidis_pkg::MD_MUL) begin
        if (b_q[0]) begin
          r_q <= r_q + a_q;
        end
        a_q <= a_q << 1;
        b_q <= b_q >> 1;
      end else begin
        if (!rem_diff[65]) begin
          r_q <= rem_diff[63:0];
          a_q <= {a_q[62:0], 1'b1};
        end else begin
          r_q <= rem_sh[63:0];
          a_q <= {a_q[62:0], 1'b0};
        end
      end
    end
  end

  assign res_o  = (op_q == pidis_pkg::MD_MUL) ? r_q : a_q;
  assign busy_o = (cnt_q != 7'd0);
  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- hdl/pid_integral_separation.sv -----
// PID controller with integral separation and derivative on the measurement.
// Depends on pidis_pkg and pidis_muldiv.
//
// Input channel (in_valid_i / in_ready_o) takes one word: setpoint_i and
// measured_i, signed Q16.16. Output channel (out_valid_o / out_ready_i)
// returns one drive_o word per input word, signed Q16.16, saturated.
// Gains, period, limits and filter cutoff are written over the APB port
// (register i at byte address 4*i); the user must write them only while the block is idle, which it does not enforce.
//
// Each word runs as nine multiplies (eight when the error is out of band
// and the integral term is skipped) and three divides in sequence on a
// single shared bit-serial multiply/divide unit, with an issue and a
// hand-off for each step, then a load of the output register. That unit
// sets the rate; one word is in work at a time, so a new word is taken
// only once the last one has left the compute steps.
// A finished drive word sits in the output register, so the next input
// word is taken while the receiver stalls; the new result then waits
// until the output register is free.
// Reset loads the register defaults (period 1.0 ms, all else zero) and
// clears the error, filter and integral state.
`default_nettype none
module pid_integral_separation (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  signed [31:0]  setpoint_i,
  input  wire  signed [31:0]  measured_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic signed [31:0]  drive_o,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [4:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // configuration
  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
  logic [30:0]        step_ms_q, err_lim_q, int_lim_q, cutoff_q;
  pidis_pkg::reg_idx_e widx;

  assign widx   = pidis_pkg::reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= '0;
      gain_i_q  <= '0;
      gain_d_q  <= '0;
      step_ms_q <= pidis_pkg::StepReset;
      err_lim_q <= '0;
      int_lim_q <= '0;
      cutoff_q  <= '0;
    end else if (psel && penable && pwrite) begin
      case (widx)
        pidis_pkg::REG_GAIN_P:  gain_p_q  <= pwdata;
        pidis_pkg::REG_GAIN_I:  gain_i_q  <= pwdata;
        pidis_pkg::REG_GAIN_D:  gain_d_q  <= pwdata;
        pidis_pkg::REG_STEP_MS: step_ms_q <= pwdata[30:0];
        pidis_pkg::REG_ERR_LIM: err_lim_q <= pwdata[30:0];
        pidis_pkg::REG_INT_LIM: int_lim_q <= pwdata[30:0];
        pidis_pkg::REG_CUTOFF:  cutoff_q  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      pidis_pkg::REG_GAIN_P:  prdata = gain_p_q;
      pidis_pkg::REG_GAIN_I:  prdata = gain_i_q;
      pidis_pkg::REG_GAIN_D:  prdata = gain_d_q;
      pidis_pkg::REG_STEP_MS: prdata = {1'b0, step_ms_q};
      pidis_pkg::REG_ERR_LIM: prdata = {1'b0, err_lim_q};
      pidis_pkg::REG_INT_LIM: prdata = {1'b0, int_lim_q};
      pidis_pkg::REG_CUTOFF:  prdata = {1'b0, cutoff_q};
      default:                prdata = '0;
    endcase
  end

  // controller state and working registers
  pidis_pkg::state_e state_q, state_d;
  logic              issued_q, issued_d;
  logic signed [31:0] last_e_q, filt_q, isum_q;
  logic signed [31:0] e_q, ms_q, newf_q, deriv_q, isum_n_q, drive_q;
  logic               use_i_q, out_valid_q;
  logic [63:0]        t_q;
  logic signed [63:0] acc_q;
  logic [24:0]        b_coef_q;

  pidis_pkg::md_req_t md_req;
  logic [63:0]        md_a, md_b, md_res;
  logic               md_busy, md_done;

  pidis_muldiv u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (md_a),
    .b_i    (md_b),
    .res_o  (md_res),
    .busy_o (md_busy),
    .done_o (md_done)
  );

  logic [30:0]        dt;
  logic signed [32:0] sub_in, diff_f, sum_e, lim_e;
  logic signed [31:0] e_in;
  logic               md_neg;
  logic signed [63:0] prod_s;
  logic signed [63:0] isum_raw, isum_cl, lim_i;
  logic               sep;

  assign dt     = (step_ms_q == 31'd0) ? 31'd1 : step_ms_q;
  assign sub_in = {setpoint_i[31], setpoint_i} - {measured_i[31], measured_i};
  assign e_in   = pidis_pkg::sat32(64'(sub_in));
  assign diff_f = {newf_q[31], newf_q} - {filt_q[31], filt_q};
  assign sum_e  = {e_q[31], e_q} + {last_e_q[31], last_e_q};
  assign lim_e  = {2'b00, err_lim_q};
  assign sep    = ($signed({e_q[31], e_q}) > lim_e) || ($signed({e_q[31], e_q}) < -lim_e);
  assign lim_i  = {33'd0, int_lim_q};
  assign prod_s = md_neg ? $signed(-md_res) : $signed(md_res);

  always_comb begin
    isum_raw = sep ? 64'sd0 : 64'(isum_q) + prod_s;
    if (isum_raw >= lim_i) begin
      isum_cl = lim_i;
    end else if (isum_raw <= -lim_i) begin
      isum_cl = -lim_i;
    end else begin
      isum_cl = isum_raw;
    end
  end

  always_comb begin
    state_d    = state_q;
    issued_d   = issued_q;
    md_req.op  = pidis_pkg::MD_MUL;
    md_a       = '0;
    md_b       = '0;
    md_neg     = 1'b0;
    case (state_q)
      pidis_pkg::S_P: begin
        md_a = {33'd0, cutoff_q};
        md_b = {33'd0, step_ms_q};
      end
      pidis_pkg::S_N: begin
        md_a = t_q;
        md_b = {48'd0, pidis_pkg::TwoPiQ13};
      end
      pidis_pkg::S_B: begin
        md_req.op = pidis_pkg::MD_DIV;
        md_a      = pidis_pkg::FiltNum + (t_q >> 1);
        md_b      = t_q;
      end
      pidis_pkg::S_FA: begin
        md_a   = {32'd0, pidis_pkg::abs32(ms_q)};
        md_b   = {39'd0, pidis_pkg::CoefOne - b_coef_q};
        md_neg = ms_q[31];
      end
      pidis_pkg::S_FB: begin
        md_a   = {32'd0, pidis_pkg::abs32(filt_q)};
        md_b   = {39'd0, b_coef_q};
        md_neg = filt_q[31];
      end
      pidis_pkg::S_DM: begin
        md_a = pidis_pkg::abs64(64'(diff_f));
        md_b = {32'd0, pidis_pkg::DerivScale};
      end
      pidis_pkg::S_DD: begin
        md_req.op = pidis_pkg::MD_DIV;
        md_a      = t_q + {34'd0, dt[30:1]};
        md_b      = {33'd0, dt};
        md_neg    = diff_f[32];
      end
      pidis_pkg::S_IM: begin
        md_a = pidis_pkg::abs64(64'(sum_e));
        md_b = {33'd0, dt};
      end
      pidis_pkg::S_ID: begin
        md_req.op = pidis_pkg::MD_DIV;
        md_a      = t_q + (pidis_pkg::IntDiv >> 1);
        md_b      = pidis_pkg::IntDiv;
        md_neg    = sum_e[32];
      end
      pidis_pkg::S_TP: begin
        md_a   = {32'd0, pidis_pkg::abs32(gain_p_q)};
        md_b   = {32'd0, pidis_pkg::abs32(e_q)};
        md_neg = gain_p_q[31] ^ e_q[31];
      end
      pidis_pkg::S_TI: begin
        md_a   = {32'd0, pidis_pkg::abs32(gain_i_q)};
        md_b   = {32'd0, pidis_pkg::abs32(isum_n_q)};
        md_neg = gain_i_q[31] ^ isum_n_q[31];
      end
      pidis_pkg::S_TD: begin
        md_a   = {32'd0, pidis_pkg::abs32(gain_d_q)};
        md_b   = {32'd0, pidis_pkg::abs32(deriv_q)};
        md_neg = gain_d_q[31] ^ deriv_q[31];
      end
      default: ;
    endcase

    md_req.start = 1'b0;
    case (state_q)
      pidis_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = pidis_pkg::S_P;
        end
      end
      pidis_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = pidis_pkg::S_IDLE;
        end
      end
      default: begin
        if (!issued_q) begin
          md_req.start = 1'b1;
          issued_d     = 1'b1;
        end else if (md_done) begin
          issued_d = 1'b0;
          case (state_q)
            pidis_pkg::S_P:  state_d = pidis_pkg::S_N;
            pidis_pkg::S_N:  state_d = pidis_pkg::S_B;
            pidis_pkg::S_B:  state_d = pidis_pkg::S_FA;
            pidis_pkg::S_FA: state_d = pidis_pkg::S_FB;
            pidis_pkg::S_FB: state_d = pidis_pkg::S_DM;
            pidis_pkg::S_DM: state_d = pidis_pkg::S_DD;
            pidis_pkg::S_DD: state_d = pidis_pkg::S_IM;
            pidis_pkg::S_IM: state_d = pidis_pkg::S_ID;
            pidis_pkg::S_ID: state_d = pidis_pkg::S_TP;
            pidis_pkg::S_TP: state_d = use_i_q ? pidis_pkg::S_TI : pidis_pkg::S_TD;
            pidis_pkg::S_TI: state_d = pidis_pkg::S_TD;
            default:         state_d = pidis_pkg::S_OUT;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pidis_pkg::S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      last_e_q    <= '0;
      filt_q      <= '0;
      isum_q      <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (state_q == pidis_pkg::S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == pidis_pkg::S_TD && md_done) begin
        last_e_q <= e_q;
        filt_q   <= newf_q;
        isum_q   <= isum_n_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pidis_pkg::S_IDLE && in_valid_i) begin
      e_q  <= e_in;
      ms_q <= measured_i;
    end
    if (state_q == pidis_pkg::S_OUT && (!out_valid_q || out_ready_i)) begin
      drive_q <= pidis_pkg::sat32(acc_q);
    end
    if (md_done) begin
      case (state_q)
        pidis_pkg::S_P:  t_q <= md_res >> 16;
        pidis_pkg::S_N:  t_q <= md_res + pidis_pkg::FiltDen;
        pidis_pkg::S_B:  b_coef_q <= md_res[24:0];
        pidis_pkg::S_FA: t_q <= prod_s;
        pidis_pkg::S_FB: newf_q <= 32'(pidis_pkg::rnd_shift($signed(t_q) + prod_s, 24));
        pidis_pkg::S_DM: t_q <= md_res << 16;
        pidis_pkg::S_DD: deriv_q <= pidis_pkg::sat32(prod_s);
        pidis_pkg::S_IM: t_q <= md_res;
        pidis_pkg::S_ID: begin
          isum_n_q <= isum_cl[31:0];
          use_i_q  <= !sep;
        end
        pidis_pkg::S_TP: acc_q <= pidis_pkg::rnd_shift(prod_s, 16);
        pidis_pkg::S_TI: acc_q <= acc_q + pidis_pkg::rnd_shift(prod_s, 16);
        pidis_pkg::S_TD: acc_q <= acc_q - pidis_pkg::rnd_shift(prod_s, 16);
        default: ;
      endcase
    end
  end

  assign in_ready_o  = (state_q == pidis_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req.start |-> !md_busy)
    else $error("multiply/divide started while busy");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after a word was accepted");

  a_done_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (issued_q && state_q != pidis_pkg::S_IDLE && state_q != pidis_pkg::S_OUT))
    else $error("unit finished outside a compute step");

  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pidis_pkg::S_FA) |-> (b_coef_q <= pidis_pkg::CoefOne))
    else $error("filter coefficient above one");
`endif

endmodule
`default_nettype wire
